>>> rtl/core/lru_page_replacement_macros.svh
// Assertion macros used by the checker file of the page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define LRUPR_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lru_page_replacement: implication check failed");

// Next-cycle implication.
`define LRUPR_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lru_page_replacement: next-cycle check failed");

`endif

>>> rtl/core/lrupr_pkg.sv
// Shared types and constants of the page replacement block.
`default_nettype none

package lrupr_pkg;

	localparam int CFG_W     = 4;
	localparam int PAGE_W    = 16;
	localparam int FRAME_W   = 3;
	localparam int EXT_W     = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIX,
		ST_FIN
	} state_t;

	// Strobes from the sequencer to the datapath and the frame store.
	typedef struct packed {
		logic start;    // input beat taken this cycle
		logic scan_rd;  // read one frame from the store
		logic step;     // frame read data valid, run the compare unit
		logic fix;      // write back the chosen frame
		logic fin;      // load the output register
	} seq_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_page_replacement.sv
// LRU page replacement, top level: sequencer, compare unit, frame store, output register.
//
// Channels: a page reference beat comes in on in_valid/in_ready with page; one
// result beat per reference leaves on out_valid/out_ready with hit, frame_index,
// evicted_valid and evicted_page. cfg_valid/cfg_ready writes frames_in_use from
// cfg_data; cfg_ready is always high and writes belong in idle periods.
// Timing: with n active frames the sequencer reads one frame per cycle from the
// store, then passes through its fix and finish states before it takes the next
// input beat; out_valid rises when the finish state loads the output register.
// The frame walk through the store's one read port and the shared compare unit sets
// the time per reference. in_ready is high only while the sequencer is idle.
// Stall: the result sits in an output register; a new reference is taken while
// it waits. If the next result is ready before the old one is taken, the
// sequencer holds until out_ready frees the register.
// Reset: arst_n clears all frames to empty (read as age zero) and frames_in_use to 8.
// No clearing pass is needed; the block is ready as soon as reset is released.
`default_nettype none

module lru_page_replacement import lrupr_pkg::*; #(
	parameter int NUM_FRAMES = 8,
	parameter int PAGE_BITS  = 16,
	parameter int AGE_BITS   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PAGE_W-1:0]  page,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [FRAME_W-1:0]      frame_index,
	output logic                    evicted_valid,
	output logic [PAGE_W-1:0]       evicted_page
);

	localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	logic [CFG_W-1:0]     frames_q;
	seq_t                 seq;
	logic [IDX_W-1:0]     rd_idx;
	logic [IDX_W-1:0]     step_idx;
	logic                 out_free;

	logic [EXT_W-1:0]     page_ext;
	logic [PAGE_BITS-1:0] page_m;

	logic [PAGE_BITS-1:0] rd_page;
	logic [AGE_BITS-1:0]  rd_age;
	logic                 rd_vld;
	logic                 age_we;
	logic [IDX_W-1:0]     age_waddr;
	logic [AGE_BITS-1:0]  age_wdata;
	logic                 page_we;
	logic [IDX_W-1:0]     page_waddr;
	logic [PAGE_BITS-1:0] page_wdata;

	logic                 res_hit;
	logic [IDX_W-1:0]     res_slot;
	logic                 res_ev_valid;
	logic [PAGE_BITS-1:0] res_ev_page;
	logic [EXT_W-1:0]     slot_ext;
	logic [EXT_W-1:0]     ev_ext;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   frame_index_q;
	logic                 evicted_valid_q;
	logic [PAGE_W-1:0]    evicted_page_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_RESET;
		end else if (cfg_valid) begin
			frames_q <= cfg_data;
		end
	end

	assign page_ext = EXT_W'(page);
	assign page_m   = page_ext[PAGE_BITS-1:0];
	assign out_free = !out_valid_q || out_ready;

	lrupr_ctrl #(
		.NUM_FRAMES (NUM_FRAMES),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frames_cfg (frames_q),
		.out_free   (out_free),
		.seq        (seq),
		.rd_idx     (rd_idx),
		.step_idx   (step_idx)
	);

	lrupr_store #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.AGE_BITS   (AGE_BITS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (seq.scan_rd),
		.rd_addr    (rd_idx),
		.rd_page    (rd_page),
		.rd_age     (rd_age),
		.rd_vld     (rd_vld),
		.age_we     (age_we),
		.age_waddr  (age_waddr),
		.age_wdata  (age_wdata),
		.page_we    (page_we),
		.page_waddr (page_waddr),
		.page_wdata (page_wdata)
	);

	lrupr_unit #(
		.PAGE_BITS (PAGE_BITS),
		.AGE_BITS  (AGE_BITS),
		.IDX_W     (IDX_W)
	) u_unit (
		.clk          (clk),
		.arst_n       (arst_n),
		.seq          (seq),
		.page_in      (page_m),
		.step_idx     (step_idx),
		.rd_page      (rd_page),
		.rd_age       (rd_age),
		.rd_vld       (rd_vld),
		.age_we       (age_we),
		.age_waddr    (age_waddr),
		.age_wdata    (age_wdata),
		.page_we      (page_we),
		.page_waddr   (page_waddr),
		.page_wdata   (page_wdata),
		.res_hit      (res_hit),
		.res_slot     (res_slot),
		.res_ev_valid (res_ev_valid),
		.res_ev_page  (res_ev_page)
	);

	assign slot_ext = EXT_W'(res_slot);
	assign ev_ext   = EXT_W'(res_ev_page);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.fin) begin
			hit_q           <= res_hit;
			frame_index_q   <= slot_ext[FRAME_W-1:0];
			evicted_valid_q <= res_ev_valid;
			evicted_page_q  <= ev_ext[PAGE_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;

endmodule

`default_nettype wire

>>> rtl/core/lrupr_ctrl.sv
// Sequencer: walks the active frames one per cycle and steps the datapath.
`default_nettype none

module lrupr_ctrl import lrupr_pkg::*; #(
	parameter int NUM_FRAMES = 8,
	parameter int IDX_W      = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [CFG_W-1:0] frames_cfg,
	input  wire logic             out_free,
	output seq_t                  seq,
	output logic [IDX_W-1:0]      rd_idx,
	output logic [IDX_W-1:0]      step_idx
);

	localparam int CMP_W = 7;
	localparam logic [CMP_W-1:0] NF_C = CMP_W'(NUM_FRAMES);

	state_t state_q, state_d;

	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] last_q;
	logic [IDX_W-1:0] last_d;
	logic             rd_done_q;
	logic             step_v_s1;
	logic [IDX_W-1:0] step_idx_s1;
	logic [CMP_W-1:0] cfg_ext;

	// Frame count 0 acts as 1, counts beyond the store saturate.
	always_comb begin
		cfg_ext = CMP_W'(frames_cfg);
		priority if (cfg_ext == '0) begin
			last_d = '0;
		end else if (cfg_ext > NF_C) begin
			last_d = IDX_W'(NUM_FRAMES - 1);
		end else begin
			last_d = IDX_W'(cfg_ext - CMP_W'(1));
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		seq         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				seq.start = in_valid;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				seq.scan_rd = !rd_done_q;
				seq.step    = step_v_s1;
				if (step_v_s1 && (step_idx_s1 == last_q)) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				seq.fix = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				seq.fin = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			last_q      <= '0;
			rd_done_q   <= 1'b0;
			step_v_s1   <= 1'b0;
			step_idx_s1 <= '0;
		end else begin
			state_q     <= state_d;
			step_v_s1   <= seq.scan_rd;
			step_idx_s1 <= rd_idx_q;
			if (seq.start) begin
				last_q    <= last_d;
				rd_idx_q  <= '0;
				rd_done_q <= 1'b0;
			end else if (seq.scan_rd) begin
				if (rd_idx_q == last_q) begin
					rd_done_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	assign rd_idx   = rd_idx_q;
	assign step_idx = step_idx_s1;

endmodule

`default_nettype wire

>>> rtl/core/lrupr_store.sv
// Frame store: page and age memories with one read and one write port, and valid bits.
`default_nettype none

module lrupr_store import lrupr_pkg::*; #(
	parameter int NUM_FRAMES = 8,
	parameter int PAGE_BITS  = 16,
	parameter int AGE_BITS   = 16,
	parameter int IDX_W      = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output logic [PAGE_BITS-1:0]      rd_page,
	output logic [AGE_BITS-1:0]       rd_age,
	output logic                      rd_vld,
	input  wire logic                 age_we,
	input  wire logic [IDX_W-1:0]     age_waddr,
	input  wire logic [AGE_BITS-1:0]  age_wdata,
	input  wire logic                 page_we,
	input  wire logic [IDX_W-1:0]     page_waddr,
	input  wire logic [PAGE_BITS-1:0] page_wdata
);

	logic [PAGE_BITS-1:0]  page_mem [NUM_FRAMES];
	logic [AGE_BITS-1:0]   age_mem  [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] valid_q;
	logic [PAGE_BITS-1:0]  rd_page_s1;
	logic [AGE_BITS-1:0]   rd_age_s1;
	logic                  rd_vld_s1;

	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_waddr] <= page_wdata;
		end
		if (age_we) begin
			age_mem[age_waddr] <= age_wdata;
		end
		if (rd_en) begin
			rd_page_s1 <= page_mem[rd_addr];
			rd_age_s1  <= age_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (page_we) begin
				valid_q[page_waddr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// A frame never filled since reset reads with age zero.
	assign rd_page = rd_page_s1;
	assign rd_age  = rd_vld_s1 ? rd_age_s1 : '0;
	assign rd_vld  = rd_vld_s1;

endmodule

`default_nettype wire

>>> rtl/core/lrupr_unit.sv
// Shared compare unit: page match, oldest-frame select and saturating age update.
`default_nettype none

module lrupr_unit import lrupr_pkg::*; #(
	parameter int PAGE_BITS = 16,
	parameter int AGE_BITS  = 16,
	parameter int IDX_W     = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire seq_t                 seq,
	input  wire logic [PAGE_BITS-1:0] page_in,
	input  wire logic [IDX_W-1:0]     step_idx,
	input  wire logic [PAGE_BITS-1:0] rd_page,
	input  wire logic [AGE_BITS-1:0]  rd_age,
	input  wire logic                 rd_vld,
	output logic                      age_we,
	output logic [IDX_W-1:0]          age_waddr,
	output logic [AGE_BITS-1:0]       age_wdata,
	output logic                      page_we,
	output logic [IDX_W-1:0]          page_waddr,
	output logic [PAGE_BITS-1:0]      page_wdata,
	output logic                      res_hit,
	output logic [IDX_W-1:0]          res_slot,
	output logic                      res_ev_valid,
	output logic [PAGE_BITS-1:0]      res_ev_page
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 found_q;
	logic [IDX_W-1:0]     hit_slot_q;
	logic                 empty_q;
	logic [IDX_W-1:0]     empty_slot_q;
	logic [AGE_BITS-1:0]  best_age_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [PAGE_BITS-1:0] best_page_q;

	logic                 res_hit_q;
	logic [IDX_W-1:0]     res_slot_q;
	logic                 res_ev_valid_q;
	logic [PAGE_BITS-1:0] res_ev_page_q;

	logic                 match;
	logic                 older;
	logic [AGE_BITS-1:0]  age_inc;
	logic [IDX_W-1:0]     slot;

	assign match   = rd_vld && (rd_page == page_q);
	assign older   = (step_idx == '0) || (rd_age > best_age_q);
	assign age_inc = (rd_age == '1) ? rd_age : rd_age + AGE_BITS'(1);

	always_comb begin
		priority if (found_q) begin
			slot = hit_slot_q;
		end else if (empty_q) begin
			slot = empty_slot_q;
		end else begin
			slot = best_slot_q;
		end
	end

	// Ages age in the walk, matches reset to zero; a miss zeroes the new frame later.
	assign age_we     = seq.step || (seq.fix && !found_q);
	assign age_waddr  = seq.fix ? slot : step_idx;
	assign age_wdata  = (seq.fix || match) ? '0 : age_inc;
	assign page_we    = seq.fix && !found_q;
	assign page_waddr = slot;
	assign page_wdata = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (seq.start) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (seq.step) begin
			if (match) begin
				found_q <= 1'b1;
			end
			if (!rd_vld) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq.start) begin
			page_q <= page_in;
		end
		if (seq.step) begin
			if (match && !found_q) begin
				hit_slot_q <= step_idx;
			end
			if (!rd_vld && !empty_q) begin
				empty_slot_q <= step_idx;
			end
			if (older) begin
				best_age_q  <= rd_age;
				best_slot_q <= step_idx;
				best_page_q <= rd_page;
			end
		end
		if (seq.fix) begin
			res_hit_q      <= found_q;
			res_slot_q     <= slot;
			res_ev_valid_q <= !found_q && !empty_q;
			res_ev_page_q  <= (!found_q && !empty_q) ? best_page_q : '0;
		end
	end

	assign res_hit      = res_hit_q;
	assign res_slot     = res_slot_q;
	assign res_ev_valid = res_ev_valid_q;
	assign res_ev_page  = res_ev_page_q;

endmodule

`default_nettype wire

>>> rtl/core/lrupr_checker.sv
// Port-level checks for the page replacement block, bound to the top level.
`default_nettype none

`include "lru_page_replacement_macros.svh"

module lrupr_checker import lrupr_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready,
	input wire logic [CFG_W-1:0]   cfg_data,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [PAGE_W-1:0]  page,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic [FRAME_W-1:0] frame_index,
	input wire logic               evicted_valid,
	input wire logic [PAGE_W-1:0]  evicted_page
);

	// A reference keeps the sequencer busy for at least the following cycle.
	`LRUPR_ASSERT_NXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result beat holds its payload.
	`LRUPR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hit) && $stable(frame_index) && $stable(evicted_valid) && $stable(evicted_page))

	// A hit never evicts.
	`LRUPR_ASSERT_IMP(a_hit_no_evict, clk, arst_n, out_valid && hit, !evicted_valid)

	// Evicted page reads zero when nothing was removed.
	`LRUPR_ASSERT_IMP(a_evict_zero, clk, arst_n, out_valid && !evicted_valid, evicted_page == '0)

	logic unused_ok;
	assign unused_ok = cfg_valid & cfg_ready & (|cfg_data) & (|page);

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the LRU page replacement block.
module tb;
	import lrupr_pkg::*;

	localparam int FRAMES      = 8;
	localparam int QUIET_LIMIT = 1000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_index;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
	} page_result_t;

	// Mirror of the frame table plus the queue of results still to come out.
	class frame_scoreboard;
		logic [CFG_W-1:0]  frames_cfg;
		logic [PAGE_W-1:0] resident[FRAMES];
		bit                occupied[FRAMES];
		logic [15:0]       age[FRAMES];
		page_result_t      expected_q[$];
		int                mismatches;
		int                refs;
		int                hits;
		int                evictions;
		int                cfg_writes;

		function new();
			frames_cfg = CFG_RESET;
			for (int i = 0; i < FRAMES; i++) begin
				resident[i] = '0;
				occupied[i] = 1'b0;
				age[i] = '0;
			end
			mismatches = 0;
			refs = 0;
			hits = 0;
			evictions = 0;
			cfg_writes = 0;
		endfunction

		function int active_frames();
			if (frames_cfg == 0)
				return 1;
			if (frames_cfg > FRAMES)
				return FRAMES;
			return int'(frames_cfg);
		endfunction

		function void age_active(int n);
			for (int i = 0; i < n; i++)
				if (age[i] != 16'hFFFF)
					age[i] = age[i] + 16'd1;
		endfunction

		function void write_count(logic [CFG_W-1:0] v);
			frames_cfg = v;
			cfg_writes++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_page(logic [PAGE_W-1:0] pg);
			int n;
			int slot;
			bit found;
			bit empty;
			page_result_t r;
			n = active_frames();
			slot = 0;
			found = 1'b0;
			empty = 1'b0;
			r = '0;
			for (int i = 0; i < n; i++)
				if (occupied[i] && resident[i] == pg) begin
					if (!found)
						slot = i;
					found = 1'b1;
				end
			if (found) begin
				age_active(n);
				// every active copy of the page is refreshed, not just the reported one
				for (int i = 0; i < n; i++)
					if (occupied[i] && resident[i] == pg)
						age[i] = '0;
				hits++;
			end else begin
				for (int i = 0; i < n; i++)
					if (!empty && !occupied[i]) begin
						slot = i;
						empty = 1'b1;
					end
				if (!empty) begin
					slot = 0;
					for (int i = 1; i < n; i++)
						if (age[i] > age[slot])
							slot = i;
					r.evicted_valid = 1'b1;
					r.evicted_page = resident[slot];
					evictions++;
				end
				resident[slot] = pg;
				occupied[slot] = 1'b1;
				age_active(n);
				age[slot] = '0;
			end
			r.hit = found;
			r.frame_index = slot[FRAME_W-1:0];
			expected_q.push_back(r);
			refs++;
		endfunction

		function void check(page_result_t got);
			page_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result beat with no reference outstanding: hit=%0b frame=%0d ev=%0b evp=%h",
						got.hit, got.frame_index, got.evicted_valid, got.evicted_page);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: hit %0b/%0b frame %0d/%0d ev_valid %0b/%0b ev_page %h/%h (exp/act)",
						want.hit, got.hit, want.frame_index, got.frame_index,
						want.evicted_valid, got.evicted_valid, want.evicted_page, got.evicted_page);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [PAGE_W-1:0]  page;
	logic               out_valid;
	logic               out_ready;
	logic               hit;
	logic [FRAME_W-1:0] frame_index;
	logic               evicted_valid;
	logic [PAGE_W-1:0]  evicted_page;

	frame_scoreboard sb;
	bit              gaps_on;
	int              quiet;
	logic [PAGE_W-1:0] hot_pages[12];

	lru_page_replacement uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page(page),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.frame_index(frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// beat monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_count(cfg_data);
			if (in_valid && in_ready)
				sb.note_page(page);
			if (out_valid && out_ready)
				sb.check('{hit, frame_index, evicted_valid, evicted_page});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet + 1 >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: ready drops in bursts, always with a ready cycle in between
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	task automatic send_page(input logic [PAGE_W-1:0] pg);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid = 1'b1;
		page = pg;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drop_in();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0 || !in_ready);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] v);
		drop_in();
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [PAGE_W-1:0] pick_page(int pool_n);
		if ($urandom_range(0, 4) == 0)
			return PAGE_W'($urandom);
		return hot_pages[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [CFG_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return CFG_W'($urandom_range(FRAMES + 1, 15));
		return CFG_W'($urandom_range(1, FRAMES));
	endfunction

	initial begin
		int sent;
		int len;
		int n;
		int pool_n;
		logic [CFG_W-1:0] cnt;
		logic [PAGE_W-1:0] pa;
		logic [PAGE_W-1:0] pb;
		logic [PAGE_W-1:0] pc;

		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		page = '0;
		gaps_on = 1'b0;
		quiet = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: fill all eight frames, hit, evict
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'h1234);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'h0001);
		send_page(16'h8000);
		send_page(16'h7FFF);
		send_page(16'hFFFF);
		send_page(16'h4321);
		// shrink, copy a page already held higher up, then grow back: duplicate hit
		write_frames(4'd2);
		send_page(16'hAAAA);
		write_frames(4'd8);
		send_page(16'hAAAA);
		// zero count behaves as one frame
		write_frames(4'd0);
		send_page(16'h0F0F);
		send_page(16'hF0F0);
		// oversized count clamps to eight
		write_frames(4'd15);
		send_page(16'h0F0F);
		send_page(16'h3C3C);

		// random phases, each with its own frame count and working set
		for (int k = 0; k < 12; k++)
			hot_pages[k] = PAGE_W'($urandom);
		sent = 0;
		while (sent < 1750) begin
			cnt = pick_count();
			write_frames(cnt);
			n = (cnt == 0) ? 1 : ((cnt > FRAMES) ? FRAMES : int'(cnt));
			pool_n = n + $urandom_range(0, 4);
			// keeping the old working set across count changes breeds duplicates
			if ($urandom_range(0, 1) == 0)
				for (int k = 0; k < 12; k++)
					hot_pages[k] = PAGE_W'($urandom);
			gaps_on = ($urandom_range(0, 3) != 0);
			len = $urandom_range(40, 140);
			for (int k = 0; k < len; k++)
				send_page(pick_page(pool_n));
			sent += len;
		end

		// keep one page hot while the other two frames age, then miss through the oldest
		gaps_on = 1'b0;
		write_frames(4'd3);
		pa = PAGE_W'($urandom);
		pb = ~pa;
		pc = pa ^ 16'h5A5A;
		send_page(pa);
		send_page(pb);
		send_page(pc);
		repeat (20) send_page(pa);
		send_page(pa + 16'd1);
		send_page(pb);
		send_page(pc);

		write_frames(4'd8);
		for (int k = 0; k < 12; k++)
			hot_pages[k] = PAGE_W'($urandom);
		for (int k = 0; k < 100; k++)
			send_page(pick_page(10));

		drop_in();
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d references over %0d frame-count writes: %0d hits, %0d evictions",
			sb.refs, sb.cfg_writes, sb.hits, sb.evictions);
		$display("includes oldest-frame eviction, duplicate pages, counts 0 and 15");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

>>> lru_page_replacement.f
+incdir+rtl/core
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_ctrl.sv
rtl/core/lrupr_store.sv
rtl/core/lrupr_unit.sv
rtl/core/lru_page_replacement.sv
rtl/core/lrupr_checker.sv
verif/tb.sv
